@@ rtl/core/segment_intersection_test_assert.svh @@
// Assertion macros for the segment intersection test.
// Included by modules under rtl/core; relies on i_clk and i_rst_n in scope.
`ifndef SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sit_pkg.sv @@
// Package for the segment intersection test: default coordinate width and the orientation sign class.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    // sign class of one orientation product
    typedef struct packed {
        logic neg;
        logic zero;
    } t_orient;

endpackage

`default_nettype wire

@@ rtl/core/segment_intersection_test.sv @@
// Segment intersection test, top level: five-stage pipeline over four
// orientation cross products. Depends on sit_pkg and segment_intersection_test_assert.svh.
//
//   channel   direction  handshake        payload
//   command   in         start / busy     i_a0_x .. i_b1_y (COORD_WIDTH each)
//   result    out        o_done strobe    o_intersects
//
// One transaction per cycle while busy is low; an accepted transaction passes
// through the stages inputs, differences, products, subtraction and sign, and
// decision before o_done strobes. busy is high only during reset and the cycle after it.
// Reset (synchronous, active low) clears all valid bits; in-flight transactions
// are dropped. The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

`include "segment_intersection_test_assert.svh"

module segment_intersection_test #(
    parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_a0_x,
    input  logic signed [COORD_WIDTH-1:0] i_a0_y,
    input  logic signed [COORD_WIDTH-1:0] i_a1_x,
    input  logic signed [COORD_WIDTH-1:0] i_a1_y,
    input  logic signed [COORD_WIDTH-1:0] i_b0_x,
    input  logic signed [COORD_WIDTH-1:0] i_b0_y,
    input  logic signed [COORD_WIDTH-1:0] i_b1_x,
    input  logic signed [COORD_WIDTH-1:0] i_b1_y,
    output logic                          o_done,
    output logic                          o_intersects
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int OW = PW + 1;

    function automatic logic signed [DW-1:0] f_sub(logic signed [COORD_WIDTH-1:0] x,
                                                   logic signed [COORD_WIDTH-1:0] y);
        return DW'(x) - DW'(y);
    endfunction

    function automatic logic signed [PW-1:0] f_mul(logic signed [DW-1:0] x,
                                                   logic signed [DW-1:0] y);
        return PW'(x) * PW'(y);
    endfunction

    function automatic sit_pkg::t_orient f_orient(logic signed [PW-1:0] p,
                                                  logic signed [PW-1:0] q);
        logic signed [OW-1:0] d;
        sit_pkg::t_orient     o;
        d      = OW'(p) - OW'(q);
        o.neg  = d[OW-1];
        o.zero = (d == '0);
        return o;
    endfunction

    logic accept;
    logic r_busy;

    // stage 1: inputs
    logic                          r_s1_vld;
    logic signed [COORD_WIDTH-1:0] r_ax0, r_ay0, r_ax1, r_ay1, r_bx0, r_by0, r_bx1, r_by1;

    // stage 2: differences and extents
    logic                          r_s2_vld;
    logic signed [DW-1:0]          r_bdx, r_bdy, r_a0bx, r_a0by, r_a1bx, r_a1by;
    logic signed [DW-1:0]          r_adx, r_ady, r_b0ax, r_b0ay, r_b1ax, r_b1ay;
    logic signed [COORD_WIDTH-1:0] r_axmin, r_axmax, r_aymin, r_aymax;
    logic signed [COORD_WIDTH-1:0] r_bxmin, r_bxmax, r_bymin, r_bymax;

    // stage 3: products
    logic                 r_s3_vld;
    logic signed [PW-1:0] r_p1, r_q1, r_p2, r_q2, r_p3, r_q3, r_p4, r_q4;
    logic                 r_s3_ov;

    // stage 4: signs
    logic            r_s4_vld;
    sit_pkg::t_orient r_o1, r_o2, r_o3, r_o4;
    logic            r_s4_ov;

    logic n_cross;
    logic n_hit;

    assign busy   = r_busy | ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            o_done   <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax0 <= i_a0_x;
        r_ay0 <= i_a0_y;
        r_ax1 <= i_a1_x;
        r_ay1 <= i_a1_y;
        r_bx0 <= i_b0_x;
        r_by0 <= i_b0_y;
        r_bx1 <= i_b1_x;
        r_by1 <= i_b1_y;
    end

    always_ff @(posedge i_clk) begin
        r_bdx   <= f_sub(r_bx1, r_bx0);
        r_bdy   <= f_sub(r_by1, r_by0);
        r_a0bx  <= f_sub(r_ax0, r_bx0);
        r_a0by  <= f_sub(r_ay0, r_by0);
        r_a1bx  <= f_sub(r_ax1, r_bx0);
        r_a1by  <= f_sub(r_ay1, r_by0);
        r_adx   <= f_sub(r_ax1, r_ax0);
        r_ady   <= f_sub(r_ay1, r_ay0);
        r_b0ax  <= f_sub(r_bx0, r_ax0);
        r_b0ay  <= f_sub(r_by0, r_ay0);
        r_b1ax  <= f_sub(r_bx1, r_ax0);
        r_b1ay  <= f_sub(r_by1, r_ay0);
        r_axmin <= (r_ax0 < r_ax1) ? r_ax0 : r_ax1;
        r_axmax <= (r_ax0 < r_ax1) ? r_ax1 : r_ax0;
        r_aymin <= (r_ay0 < r_ay1) ? r_ay0 : r_ay1;
        r_aymax <= (r_ay0 < r_ay1) ? r_ay1 : r_ay0;
        r_bxmin <= (r_bx0 < r_bx1) ? r_bx0 : r_bx1;
        r_bxmax <= (r_bx0 < r_bx1) ? r_bx1 : r_bx0;
        r_bymin <= (r_by0 < r_by1) ? r_by0 : r_by1;
        r_bymax <= (r_by0 < r_by1) ? r_by1 : r_by0;
    end

    always_ff @(posedge i_clk) begin
        r_p1    <= f_mul(r_a0by, r_bdx);
        r_q1    <= f_mul(r_bdy, r_a0bx);
        r_p2    <= f_mul(r_a1by, r_bdx);
        r_q2    <= f_mul(r_bdy, r_a1bx);
        r_p3    <= f_mul(r_b0ay, r_adx);
        r_q3    <= f_mul(r_ady, r_b0ax);
        r_p4    <= f_mul(r_b1ay, r_adx);
        r_q4    <= f_mul(r_ady, r_b1ax);
        r_s3_ov <= (r_axmax >= r_bxmin) && (r_bxmax >= r_axmin)
                && (r_aymax >= r_bymin) && (r_bymax >= r_aymin);
    end

    always_ff @(posedge i_clk) begin
        r_o1    <= f_orient(r_p1, r_q1);
        r_o2    <= f_orient(r_p2, r_q2);
        r_o3    <= f_orient(r_p3, r_q3);
        r_o4    <= f_orient(r_p4, r_q4);
        r_s4_ov <= r_s3_ov;
    end

    // signs differ when the {neg, zero} classes differ
    always_comb begin
        n_cross = (r_o1 != r_o2) && (r_o3 != r_o4);
        if (n_cross) begin
            n_hit = 1'b1;
        end else if (r_o1.zero && r_o2.zero) begin
            n_hit = r_s4_ov;
        end else begin
            n_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        o_intersects <= n_hit;
    end

    `SIT_ASSERT_NEXT(a_accept_enters, accept, r_s1_vld, "accepted transaction not in stage 1")
    `SIT_ASSERT_NEXT(a_done_follows, r_s4_vld, o_done, "stage 4 transaction not delivered")
    `SIT_ASSERT_NOW(a_done_source, o_done, $past(r_s4_vld), "result strobe without stage 4 data")
    `SIT_ASSERT_NEXT(a_not_busy, i_rst_n && $past(i_rst_n), !busy, "busy outside reset")
    `SIT_ASSERT_NEXT(a_collinear_apart,
        r_s4_vld && r_o1.zero && r_o2.zero && !r_s4_ov, !o_intersects,
        "disjoint collinear segments reported as hit")

endmodule

`default_nettype wire
